@@ design/lobt_pkg.sv @@
// Shared types, field widths and neighbour offsets for the owner lattice store.
package lobt_pkg;

	localparam int ID_W   = 24;
	localparam int TYPE_W = 7;
	localparam int ACT_W  = 31;
	localparam int POS_W  = 6;
	localparam int DIR_W  = 4;
	localparam int TOT_W  = 13;
	localparam int NBR    = 8;
	localparam int WIN    = 5;
	localparam int WIN_N  = WIN * WIN;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [DIR_W-1:0]  direction;
		logic [ID_W-1:0]   cell_id;
		logic [TYPE_W-1:0] cell_type;
		logic [ACT_W-1:0]  time_stamp;
	} in_word_t;

	typedef struct packed {
		logic [ID_W-1:0]   out_id;
		logic [TYPE_W-1:0] out_type;
		logic [POS_W-1:0]  out_x;
		logic [POS_W-1:0]  out_y;
		logic [ACT_W-1:0]  out_act;
		logic              on_border;
		logic [TOT_W-1:0]  border_total;
	} out_word_t;

	function automatic logic signed [2:0] off_dx(input logic [2:0] d);
		logic signed [2:0] r;
		case (d)
			3'd0: r = -3'sd1;
			3'd1: r = 3'sd0;
			3'd2: r = 3'sd1;
			3'd3: r = 3'sd1;
			3'd4: r = 3'sd1;
			3'd5: r = 3'sd0;
			3'd6: r = -3'sd1;
			default: r = -3'sd1;
		endcase
		return r;
	endfunction

	function automatic logic signed [2:0] off_dy(input logic [2:0] d);
		logic signed [2:0] r;
		case (d)
			3'd0: r = 3'sd1;
			3'd1: r = 3'sd1;
			3'd2: r = 3'sd1;
			3'd3: r = 3'sd0;
			3'd4: r = -3'sd1;
			3'd5: r = -3'sd1;
			3'd6: r = -3'sd1;
			default: r = 3'sd0;
		endcase
		return r;
	endfunction

endpackage

@@ design/lobt_chan_if.sv @@
// Valid/ready channel carrying one word.
interface lobt_chan_if #(parameter type word_t = logic) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/lattice_owner_store_border_track_core.sv @@
// Toroidal owner lattice with per-site border marks and a running border count.
//
//   channel   dir   word         notes
//   req       in    in_word_t    write site or read site/neighbour
//   rsp       out   out_word_t   one word per request
//   cfg       in    1 bit        act_enable, cfg_we/cfg_wdata
//
// A read: the accept cycle reads the stores, and ST_FIN loads rsp once it is free.
// A write: the store cycle, then ST_SCAN reads the 5x5 owner window over the
// single owner port, ST_MARK does the 9 border read-modify-writes, and ST_FIN loads rsp.
// After reset a sweep clears all 2^(2*LOG_SIDE) sites, one per cycle, before
// req is ready. A finished word waits in the rsp register while the next request
// is taken; a request finishing behind a stalled rsp holds until it drains.
module lattice_owner_store_border_track_core import lobt_pkg::*; #(
	parameter int LOG_SIDE = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	lobt_chan_if.sink           req,
	lobt_chan_if.source         rsp
);

	localparam int LS    = LOG_SIDE;
	localparam int AW    = 2 * LOG_SIDE;
	localparam int SITES = 1 << AW;
	localparam int CW    = AW + 1;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_MARK  = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	logic [ID_W+TYPE_W-1:0] own_mem [SITES];
	logic [ACT_W-1:0]       stp_mem [SITES];
	logic                   bd_mem  [SITES];

	state_t                 st_q;
	logic [AW-1:0]          clr_q;
	logic                   act_en_q;
	logic                   kind_q;
	logic [LS-1:0]          bx_q, by_q, ox_q, oy_q;
	logic [2:0]             wx_q, wy_q;
	logic                   scan_end_q;
	logic                   scan_v_s1;
	logic [4:0]             scan_k_s1;
	logic [ID_W-1:0]        win_q [WIN_N];
	logic [3:0]             tgt_q;
	logic                   mark_v_s1, mark_s1, mlast_s1, mfirst_s1;
	logic [AW-1:0]          maddr_s1;
	logic                   cmark_q;
	logic [CW-1:0]          cnt_q;
	logic [ID_W+TYPE_W-1:0] own_rd_q;
	logic [ACT_W-1:0]       stp_rd_q;
	logic                   bd_rd_q;
	out_word_t              out_q;
	logic                   out_v_q;

	logic                   accept;
	logic [LS-1:0]          in_x, in_y, rx, ry;
	logic                   own_re, bd_re;
	logic [AW-1:0]          own_ra, bd_ra;
	logic                   scan_issue, mark_issue;
	logic [LS-1:0]          sx, sy, tx, ty;
	logic signed [3:0]      sdx, sdy;
	logic signed [2:0]      tdx, tdy;
	logic                   tmark;
	logic                   fin_go;

	assign req.ready = (st_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	always_comb begin
		in_x = LS'(req.data.pos_x);
		in_y = LS'(req.data.pos_y);
		if (req.data.direction[3]) begin
			rx = in_x;
			ry = in_y;
		end else begin
			rx = in_x + LS'(off_dx(req.data.direction[2:0]));
			ry = in_y + LS'(off_dy(req.data.direction[2:0]));
		end
	end

	always_comb begin
		sdx = signed'({1'b0, wx_q}) - 4'sd2;
		sdy = signed'({1'b0, wy_q}) - 4'sd2;
		sx  = bx_q + LS'(sdx);
		sy  = by_q + LS'(sdy);
		if (tgt_q == 4'd0) begin
			tdx = 3'sd0;
			tdy = 3'sd0;
		end else begin
			tdx = off_dx(3'(tgt_q - 4'd1));
			tdy = off_dy(3'(tgt_q - 4'd1));
		end
		tx = bx_q + LS'(tdx);
		ty = by_q + LS'(tdy);
	end

	always_comb begin
		int ci, ni;
		ci    = (int'(tdy) + 2) * WIN + int'(tdx) + 2;
		tmark = 1'b0;
		for (int d = 0; d < NBR; d++) begin
			ni = (int'(tdy) + int'(off_dy(3'(d))) + 2) * WIN
			   + int'(tdx) + int'(off_dx(3'(d))) + 2;
			if (win_q[5'(ni)] != win_q[5'(ci)])
				tmark = 1'b1;
		end
	end

	assign scan_issue = (st_q == ST_SCAN) && !scan_end_q;
	assign mark_issue = (st_q == ST_MARK) && (tgt_q <= 4'd8);
	assign own_re     = scan_issue || (accept && req.data.kind == KIND_READ);
	assign own_ra     = scan_issue ? {sy, sx} : {ry, rx};
	assign bd_re      = mark_issue || (accept && req.data.kind == KIND_READ);
	assign bd_ra      = mark_issue ? {ty, tx} : {ry, rx};
	assign fin_go     = (st_q == ST_FIN) && (!out_v_q || rsp.ready);

	always_ff @(posedge clk) begin
		if (st_q == ST_CLEAR) begin
			own_mem[clr_q] <= '0;
			stp_mem[clr_q] <= '0;
		end else if (accept && req.data.kind == KIND_WRITE) begin
			own_mem[{in_y, in_x}] <= {req.data.cell_type, req.data.cell_id};
			stp_mem[{in_y, in_x}] <= req.data.time_stamp;
		end
		if (own_re)
			own_rd_q <= own_mem[own_ra];
		if (accept)
			stp_rd_q <= stp_mem[{ry, rx}];
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_CLEAR)
			bd_mem[clr_q] <= 1'b0;
		else if (mark_v_s1)
			bd_mem[maddr_s1] <= mark_s1;
		if (bd_re)
			bd_rd_q <= bd_mem[bd_ra];
	end

	always_ff @(posedge clk) begin
		if (scan_v_s1)
			win_q[scan_k_s1] <= own_rd_q[ID_W-1:0];
		if (accept) begin
			kind_q <= req.data.kind;
			bx_q   <= in_x;
			by_q   <= in_y;
			ox_q   <= (req.data.kind == KIND_WRITE) ? in_x : rx;
			oy_q   <= (req.data.kind == KIND_WRITE) ? in_y : ry;
		end
		scan_k_s1 <= 5'(wy_q) * 5'd5 + 5'(wx_q);
		mark_s1   <= tmark;
		maddr_s1  <= {ty, tx};
		mlast_s1  <= (tgt_q == 4'd8);
		mfirst_s1 <= (tgt_q == 4'd0);
		if (mark_v_s1 && mfirst_s1)
			cmark_q <= mark_s1;
		if (fin_go) begin
			if (kind_q == KIND_WRITE) begin
				out_q.out_id    <= '0;
				out_q.out_type  <= '0;
				out_q.out_act   <= '0;
				out_q.on_border <= cmark_q;
			end else begin
				out_q.out_id    <= own_rd_q[ID_W-1:0];
				out_q.out_type  <= own_rd_q[ID_W+TYPE_W-1:ID_W];
				out_q.out_act   <= act_en_q ? stp_rd_q : '0;
				out_q.on_border <= bd_rd_q;
			end
			out_q.out_x        <= POS_W'(ox_q);
			out_q.out_y        <= POS_W'(oy_q);
			out_q.border_total <= TOT_W'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_CLEAR;
			clr_q      <= '0;
			act_en_q   <= 1'b0;
			wx_q       <= '0;
			wy_q       <= '0;
			scan_end_q <= 1'b0;
			scan_v_s1  <= 1'b0;
			tgt_q      <= '0;
			mark_v_s1  <= 1'b0;
			cnt_q      <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_we)
				act_en_q <= cfg_wdata;
			scan_v_s1 <= scan_issue;
			mark_v_s1 <= mark_issue;
			if (scan_issue) begin
				if (wx_q == 3'd4) begin
					wx_q <= '0;
					wy_q <= wy_q + 3'd1;
					if (wy_q == 3'd4)
						scan_end_q <= 1'b1;
				end else begin
					wx_q <= wx_q + 3'd1;
				end
			end
			if (mark_issue)
				tgt_q <= tgt_q + 4'd1;
			if (mark_v_s1) begin
				if (mark_s1 && !bd_rd_q)
					cnt_q <= cnt_q + CW'(1);
				else if (!mark_s1 && bd_rd_q)
					cnt_q <= cnt_q - CW'(1);
			end
			if (fin_go)
				out_v_q <= 1'b1;
			else if (rsp.ready)
				out_v_q <= 1'b0;
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q)
						st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						wx_q       <= '0;
						wy_q       <= '0;
						scan_end_q <= 1'b0;
						tgt_q      <= '0;
						st_q       <= (req.data.kind == KIND_WRITE) ? ST_SCAN : ST_FIN;
					end
				end
				ST_SCAN: begin
					if (scan_v_s1 && scan_k_s1 == 5'(WIN_N - 1))
						st_q <= ST_MARK;
				end
				ST_MARK: begin
					if (mark_v_s1 && mlast_s1)
						st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ test/tb_top.sv @@
// Testbench for the owner lattice store: predicts each response word and checks it field by field.
module tb_top;
	import lobt_pkg::*;

	localparam int SIDE  = 64;
	localparam int SITES = SIDE * SIDE;
	localparam longint LIMIT = 3000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	lobt_chan_if #(.word_t(in_word_t))  req ();
	lobt_chan_if #(.word_t(out_word_t)) rsp ();

	lattice_owner_store_border_track_core #(.LOG_SIDE(6)) DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req.sink), .rsp(rsp.source)
	);

	logic [ID_W-1:0]   lat_id [SITES];
	logic [TYPE_W-1:0] lat_type [SITES];
	logic [ACT_W-1:0]  lat_stamp [SITES];
	logic              lat_mark [SITES];
	int                mark_total;
	logic              stamp_on;
	out_word_t         pending_rsp [$];
	int                errors;
	int                send_idle_pct;
	int                recv_stall_pct;
	longint            cycle_count;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int site_index(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
		return int'(y) * SIDE + int'(x);
	endfunction

	function automatic logic [POS_W-1:0] wrap_add(input logic [POS_W-1:0] p, input int dv);
		return POS_W'(int'(p) + dv);
	endfunction

	function automatic int nbr_dx(input int d);
		int tx[NBR] = '{-1, 0, 1, 1, 1, 0, -1, -1};
		return tx[d];
	endfunction

	function automatic int nbr_dy(input int d);
		int ty[NBR] = '{1, 1, 1, 0, -1, -1, -1, 0};
		return ty[d];
	endfunction

	function automatic logic site_differs(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
		logic r;
		r = 1'b0;
		for (int d = 0; d < NBR; d++) begin
			if (lat_id[site_index(wrap_add(x, nbr_dx(d)), wrap_add(y, nbr_dy(d)))]
					!= lat_id[site_index(x, y)])
				r = 1'b1;
		end
		return r;
	endfunction

	task automatic remark_site(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
		int s;
		logic m;
		s = site_index(x, y);
		m = site_differs(x, y);
		if (m && !lat_mark[s])
			mark_total++;
		else if (!m && lat_mark[s])
			mark_total--;
		lat_mark[s] = m;
	endtask

	task automatic predict_lattice(input in_word_t w);
		out_word_t o;
		logic [POS_W-1:0] rx, ry;
		int s;
		o = '0;
		rx = w.pos_x;
		ry = w.pos_y;
		if (w.kind == KIND_WRITE) begin
			s = site_index(rx, ry);
			lat_id[s] = w.cell_id;
			lat_type[s] = w.cell_type;
			lat_stamp[s] = w.time_stamp;
			remark_site(rx, ry);
			for (int d = 0; d < NBR; d++)
				remark_site(wrap_add(rx, nbr_dx(d)), wrap_add(ry, nbr_dy(d)));
		end else begin
			if (w.direction < NBR) begin
				rx = wrap_add(w.pos_x, nbr_dx(w.direction));
				ry = wrap_add(w.pos_y, nbr_dy(w.direction));
			end
			s = site_index(rx, ry);
			o.out_id = lat_id[s];
			o.out_type = lat_type[s];
			o.out_act = stamp_on ? lat_stamp[s] : '0;
		end
		o.out_x = rx;
		o.out_y = ry;
		o.on_border = lat_mark[s];
		o.border_total = TOT_W'(mark_total);
		pending_rsp = {pending_rsp, o};
	endtask

	task automatic send_word(input in_word_t w);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.data <= w;
		req.valid <= 1'b1;
		do @(posedge clk); while (!req.ready);
		predict_lattice(w);
		@(negedge clk);
	endtask

	function automatic in_word_t make_write(input int x, input int y, input int id);
		in_word_t w;
		w = '0;
		w.kind = KIND_WRITE;
		w.pos_x = POS_W'(x);
		w.pos_y = POS_W'(y);
		w.direction = DIR_W'($urandom);
		w.cell_id = ID_W'(id);
		w.cell_type = TYPE_W'($urandom);
		w.time_stamp = ACT_W'($urandom);
		return w;
	endfunction

	function automatic in_word_t make_read(input int x, input int y, input int d);
		in_word_t w;
		w = '0;
		w.kind = KIND_READ;
		w.pos_x = POS_W'(x);
		w.pos_y = POS_W'(y);
		w.direction = DIR_W'(d);
		w.cell_id = ID_W'($urandom);
		w.cell_type = TYPE_W'($urandom);
		w.time_stamp = ACT_W'($urandom);
		return w;
	endfunction

	task automatic drain_and_set(input logic en);
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= en;
		@(negedge clk);
		cfg_we <= 1'b0;
		stamp_on = en;
	endtask

	task automatic test_directed();
		send_word(make_read(0, 0, 8));
		send_word(make_write(0, 0, 24'hFFFFFF));
		send_word(make_write(63, 63, 0));
		send_word(make_write(63, 0, 24'h000001));
		for (int d = 0; d < 16; d++)
			send_word(make_read(0, 0, d));
		send_word(make_write(0, 0, 0));
		send_word(make_read(63, 63, 2));
		send_word(make_read(1, 1, 15));
	endtask

	// clustered writes so borders form and dissolve, plus reads nearby
	task automatic test_random(input int count);
		int cx, cy;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				cx = $urandom_range(63, 0);
				cy = $urandom_range(63, 0);
			end
			if ($urandom_range(1, 0))
				send_word(make_write(cx + $urandom_range(4, 0) - 2,
					cy + $urandom_range(4, 0) - 2,
					$urandom_range(9, 0) == 0 ? $urandom : $urandom_range(2, 0)));
			else
				send_word(make_read(cx + $urandom_range(4, 0) - 2,
					cy + $urandom_range(4, 0) - 2, $urandom_range(15, 0)));
		end
	endtask

	task automatic test_phases();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(130);
		drain_and_set(1'b1);
		send_idle_pct = 47;
		test_random(130);
		send_idle_pct = 0;
		recv_stall_pct = 47;
		test_random(130);
		drain_and_set(1'b0);
		send_idle_pct = 10;
		recv_stall_pct = 10;
		test_random(65);
		drain_and_set(1'b1);
		test_random(65);
	endtask

	always @(posedge clk) begin
		out_word_t got, want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = rsp.data;
			if (pending_rsp.size() == 0) begin
				$error("unexpected response word");
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (got.out_id !== want.out_id) begin
					$error("out_id exp %0d got %0d", want.out_id, got.out_id);
					errors++;
				end
				if (got.out_type !== want.out_type) begin
					$error("out_type exp %0d got %0d", want.out_type, got.out_type);
					errors++;
				end
				if (got.out_x !== want.out_x) begin
					$error("out_x exp %0d got %0d", want.out_x, got.out_x);
					errors++;
				end
				if (got.out_y !== want.out_y) begin
					$error("out_y exp %0d got %0d", want.out_y, got.out_y);
					errors++;
				end
				if (got.out_act !== want.out_act) begin
					$error("out_act exp %0d got %0d", want.out_act, got.out_act);
					errors++;
				end
				if (got.on_border !== want.on_border) begin
					$error("on_border exp %0d got %0d", want.on_border, got.on_border);
					errors++;
				end
				if (got.border_total !== want.border_total) begin
					$error("border_total exp %0d got %0d", want.border_total,
						got.border_total);
					errors++;
				end
			end
		end
	end

	always @(negedge clk)
		rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		cycle_count = 0;
		errors = 0;
		mark_total = 0;
		stamp_on = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < SITES; i++) begin
			lat_id[i] = '0;
			lat_type[i] = '0;
			lat_stamp[i] = '0;
			lat_mark[i] = 1'b0;
		end
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b1;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		drain_and_set(1'b1);
		test_directed();
		drain_and_set(1'b0);
		test_directed();
		test_phases();
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

@@ files.f @@
design/lobt_pkg.sv
design/lobt_chan_if.sv
design/lattice_owner_store_border_track_core.sv
test/tb_top.sv
